FILE: rtl/byte_ring_fifo_burst_read_top_defines.svh
// Assertion macros for the byte ring FIFO RTL.
// Uses the clock i_clk and reset i_rst_n of the module that expands them.
`ifndef BYTE_RING_FIFO_BURST_READ_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_BURST_READ_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define BRFB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define BRFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/brfb_pkg.sv
// Types, constants and pointer helpers for the byte ring FIFO.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package brfb_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int DATA_W = 8;
    localparam int LEN_W  = 8;
    localparam int ACT_W  = 3;
    localparam int FILL_W = 4;
    localparam int CMP_W  = (PTR_W > LEN_W) ? PTR_W : LEN_W;

    // command queue between front and back; depth must be a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_ENQ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BURST = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        OP_ENQ,
        OP_DEQ,
        OP_BURST,
        OP_PEEK,
        OP_CLEAR,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              data_valid;
        logic              ok;
        logic              last;
        logic [FILL_W-1:0] fill_count;
        logic              is_full;
        logic              is_empty;
    } t_res;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // (wr - rd) mod DEPTH
    function automatic logic [PTR_W-1:0] fifo_count(input logic [PTR_W-1:0] wr,
                                                    input logic [PTR_W-1:0] rd);
        logic [PTR_W:0] t;
        t = {1'b0, wr} + (PTR_W + 1)'(DEPTH) - {1'b0, rd};
        if (wr >= rd) begin
            return wr - rd;
        end
        return PTR_W'(t);
    endfunction

endpackage

FILE: rtl/brfb_front.sv
// Front end: takes input requests and classifies the action code.
// Depends on brfb_pkg; feeds brfb_cmdq.
`timescale 1ns / 1ps

module brfb_front (
    input  logic                        i_valid,
    input  logic [brfb_pkg::ACT_W-1:0]  i_action,
    input  logic [brfb_pkg::DATA_W-1:0] i_data_in,
    input  logic [brfb_pkg::LEN_W-1:0]  i_burst_len,
    output logic                        o_stall,
    input  logic                        i_q_full,
    output logic                        o_push,
    output brfb_pkg::t_cmd              o_cmd
);
    import brfb_pkg::*;

    t_op op;

    always_comb begin
        unique case (i_action)
            ACT_ENQ:   op = OP_ENQ;
            ACT_DEQ:   op = OP_DEQ;
            ACT_BURST: op = OP_BURST;
            ACT_PEEK:  op = OP_PEEK;
            ACT_CLEAR: op = OP_CLEAR;
            default:   op = OP_BAD;
        endcase
    end

    assign o_stall      = i_q_full;
    assign o_push       = i_valid && !i_q_full;
    assign o_cmd.op     = op;
    assign o_cmd.data   = i_data_in;
    assign o_cmd.len    = i_burst_len;

endmodule

FILE: rtl/brfb_cmdq.sv
// Short command queue between the front end and the execution unit.
// Depends on brfb_pkg.
`timescale 1ns / 1ps

module brfb_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brfb_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output brfb_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import brfb_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_head, n_head;
    logic [QPTR_W-1:0] r_tail, n_tail;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_tail = r_tail + QPTR_W'(1);
        end
        if (i_pop) begin
            n_head = r_head + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_cmd;
        end
    end

    assign o_cmd   = r_slot[r_head];
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

FILE: rtl/brfb_exec.sv
// Execution unit: ring pointers, byte store, burst sequencer, result register.
// Depends on brfb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "byte_ring_fifo_burst_read_top_defines.svh"

module brfb_exec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  brfb_pkg::t_cmd i_cmd,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output brfb_pkg::t_res o_res
);
    import brfb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [PTR_W-1:0]  r_remain, n_remain;
    logic              r_pop, n_pop;
    logic              r_out_valid, n_out_valid;
    t_res              r_res, n_res;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic              out_free;
    logic              load;
    logic              mem_we;
    logic              empty;
    logic              full;
    logic [PTR_W-1:0]  cnt;
    logic [PTR_W-1:0]  burst_n;
    logic [PTR_W-1:0]  n_cnt;
    logic [DATA_W-1:0] res_data;
    logic              res_dv;
    logic              res_ok;
    logic              res_last;

    always_comb begin
        out_free    = !r_out_valid || !i_stall;
        n_state     = r_state;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_remain    = r_remain;
        n_pop       = r_pop;
        n_out_valid = r_out_valid && i_stall;
        n_res       = r_res;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        load        = 1'b0;
        res_data    = '0;
        res_dv      = 1'b0;
        res_ok      = 1'b0;
        res_last    = 1'b1;

        cnt   = fifo_count(r_wr, r_rd);
        empty = (r_wr == r_rd);
        full  = (ptr_inc(r_wr) == r_rd);
        // burst length clamped to the bytes held
        burst_n = (CMP_W'(i_cmd.len) < CMP_W'(cnt)) ? PTR_W'(i_cmd.len) : cnt;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_ENQ: begin
                            load = 1'b1;
                            if (!full) begin
                                mem_we = 1'b1;
                                n_wr   = ptr_inc(r_wr);
                                res_ok = 1'b1;
                            end
                        end
                        OP_DEQ: begin
                            if (empty) begin
                                load = 1'b1;
                            end else begin
                                n_state  = S_EMIT;
                                n_remain = PTR_W'(1);
                                n_pop    = 1'b1;
                            end
                        end
                        OP_BURST: begin
                            if (empty) begin
                                load = 1'b1;
                            end else if (burst_n == '0) begin
                                load   = 1'b1;
                                res_ok = 1'b1;
                            end else begin
                                n_state  = S_EMIT;
                                n_remain = burst_n;
                                n_pop    = 1'b1;
                            end
                        end
                        OP_PEEK: begin
                            if (empty) begin
                                load   = 1'b1;
                                res_ok = 1'b1;
                            end else begin
                                n_state  = S_EMIT;
                                n_remain = PTR_W'(1);
                                n_pop    = 1'b0;
                            end
                        end
                        OP_CLEAR: begin
                            load   = 1'b1;
                            res_ok = 1'b1;
                            n_wr   = '0;
                            n_rd   = '0;
                        end
                        OP_BAD: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                // read data for the advanced pointer lands next cycle
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    load     = 1'b1;
                    res_data = r_rdata;
                    res_dv   = 1'b1;
                    res_ok   = 1'b1;
                    res_last = (r_remain == PTR_W'(1));
                    if (r_pop) begin
                        n_rd = ptr_inc(r_rd);
                    end
                    n_remain = r_remain - PTR_W'(1);
                    n_state  = res_last ? S_IDLE : S_WAIT;
                end
            end
        endcase

        n_cnt = fifo_count(n_wr, n_rd);
        if (load) begin
            n_out_valid      = 1'b1;
            n_res.data_out   = res_data;
            n_res.data_valid = res_dv;
            n_res.ok         = res_ok;
            n_res.last       = res_last;
            n_res.fill_count = FILL_W'(n_cnt);
            n_res.is_full    = (ptr_inc(n_wr) == n_rd);
            n_res.is_empty   = (n_wr == n_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr        <= '0;
            r_rd        <= '0;
            r_remain    <= '0;
            r_pop       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_remain    <= n_remain;
            r_pop       <= n_pop;
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
    end

    // byte store: one write port, registered read at the read pointer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr] <= i_cmd.data;
        end
        r_rdata <= r_mem[r_rd];
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    `BRFB_ASSERT_NOW(a_flags_excl, r_out_valid && r_res.is_full, !r_res.is_empty, "full and empty")
    `BRFB_ASSERT_NOW(a_busy_remain, r_state != S_IDLE, r_remain != '0, "busy with nothing left")
    `BRFB_ASSERT_NOW(a_pop_nonempty, (r_state == S_EMIT) && r_pop, r_wr != r_rd, "pop from empty")
    `BRFB_ASSERT_NEXT(a_last_idle, load && n_res.last, r_state == S_IDLE, "busy after last")

endmodule

FILE: rtl/byte_ring_fifo_burst_read_top.sv
// Top level of the byte ring FIFO with burst read.
// Depends on brfb_pkg, brfb_front, brfb_cmdq and brfb_exec.
`timescale 1ns / 1ps

// Byte FIFO over a ring of DEPTH slots (one kept free, so DEPTH-1 bytes max).
// Each request carries an action: enqueue, dequeue, burst dequeue, peek or
// clear; unknown codes are refused. Every request yields one result, except
// a burst that reads n = min(burst_len, count) bytes, which yields n results
// with last set on the final one. Each result reports the fill count and the
// full/empty flags as they stand after it. Requests pass through a two-entry
// command queue into the execution unit, so the input side keeps taking
// requests while a result waits in the output register. Throughput: requests
// that read no byte (enqueue, clear, refused or empty cases, zero-length
// burst) retire one per cycle unless the result channel stalls. Requests
// that return a byte pay for the registered read of the byte store: they go
// from idle to the emit state, and a burst passes a wait state before each
// byte after the first. A request passes the queue, the result register
// and, if it reads a byte, the emit state. No clearing pass is needed after
// reset; store contents are only ever read after an enqueue wrote them.

module byte_ring_fifo_burst_read_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [brfb_pkg::ACT_W-1:0]  i_action,
    input  logic [brfb_pkg::DATA_W-1:0] i_data_in,
    input  logic [brfb_pkg::LEN_W-1:0]  i_burst_len,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [brfb_pkg::DATA_W-1:0] o_data_out,
    output logic                        o_data_valid,
    output logic                        o_ok,
    output logic                        o_last,
    output logic [brfb_pkg::FILL_W-1:0] o_fill_count,
    output logic                        o_is_full,
    output logic                        o_is_empty
);
    import brfb_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;
    t_res res;

    // decode and push into the queue; stall only when the queue is full
    brfb_front u_front (
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_data_in   (i_data_in),
        .i_burst_len (i_burst_len),
        .o_stall     (o_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    brfb_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    // pointers, byte store and burst sequencer live here
    brfb_exec u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_cmd),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (res)
    );

    assign o_data_out   = res.data_out;
    assign o_data_valid = res.data_valid;
    assign o_ok         = res.ok;
    assign o_last       = res.last;
    assign o_fill_count = res.fill_count;
    assign o_is_full    = res.is_full;
    assign o_is_empty   = res.is_empty;

endmodule
